/* rtl/rgba_window_convolution_unit_defines.svh */
// assertion macros used by the convolution unit line window rtl
`ifndef RGBA_WINDOW_CONVOLUTION_UNIT_DEFINES_SVH
`define RGBA_WINDOW_CONVOLUTION_UNIT_DEFINES_SVH

// condition must hold in the same cycle
`define RWC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rwc check failed");

// condition must hold in the cycle after the antecedent
`define RWC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rwc check failed");

`endif

/* rtl/rwc_pkg.sv */
// shared types, constants and helpers for the rgba window convolution unit
package rwc_pkg;
    localparam int MAX_K      = 7;
    localparam int TAPS       = MAX_K * MAX_K;
    localparam int LINE_ROWS  = MAX_K - 1;
    localparam int MAX_WIDTH  = 4096;
    localparam int MAX_HEIGHT = 4096;
    localparam int X_BITS     = 12;
    localparam int DIM_BITS   = 13;
    localparam int COEF_BITS  = 16;
    localparam int PIX_BITS   = 32;
    localparam int PROD_BITS  = COEF_BITS + 8;
    localparam int ROW_BITS   = PROD_BITS + 3;
    localparam int SUM_BITS   = PROD_BITS + 6;
    localparam int LINE_WORD  = LINE_ROWS * PIX_BITS;
    localparam int IDX_BITS   = 6;

    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_KERNEL = 2'd2;

    localparam logic FUNC_COEF  = 1'b0;
    localparam logic FUNC_PIXEL = 1'b1;

    typedef logic [TAPS-1:0][PIX_BITS-1:0]  t_win;
    typedef logic [TAPS-1:0][COEF_BITS-1:0] t_coefs;

    typedef struct packed {
        logic              valid;
        logic [X_BITS-1:0] x;
        logic [X_BITS-1:0] y;
        logic              frame_end;
    } t_meta;

    // coefficient slot for window tap (i, j) under kernel side k: {hit, index}
    function automatic logic [IDX_BITS:0] coef_slot(input int i, input int j, input int k);
        int base;
        int idx;
        logic [IDX_BITS:0] res;
        base = MAX_K - k;
        idx  = 0;
        res  = '0;
        if (i >= base && j >= base) begin
            idx = (i - base) * k + (j - base);
            res = {1'b1, idx[IDX_BITS-1:0]};
        end
        return res;
    endfunction
endpackage

/* rtl/rwc_ram.sv */
// generic single write port ram with registered read
module rwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* rtl/rwc_line_window.sv */
// config registers, raster counters, line memory, coefficient store and window
`include "rgba_window_convolution_unit_defines.svh"
module rwc_line_window (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_adv,
    input  logic                               i_valid,
    input  logic                               i_func,
    input  logic [rwc_pkg::IDX_BITS-1:0]       i_coef_index,
    input  logic [rwc_pkg::COEF_BITS-1:0]      i_coef_value,
    input  logic [rwc_pkg::PIX_BITS-1:0]       i_px,
    input  logic                               i_cfg_we,
    input  logic [1:0]                         i_cfg_addr,
    input  logic [rwc_pkg::DIM_BITS-1:0]       i_cfg_data,
    output rwc_pkg::t_win                      o_win,
    output rwc_pkg::t_coefs                    o_coefs,
    output rwc_pkg::t_meta                     o_meta
);
    logic [rwc_pkg::DIM_BITS-1:0] r_w, r_h;
    logic [2:0]                   r_k;
    logic [rwc_pkg::X_BITS-1:0]   r_col, r_row;
    logic [rwc_pkg::DIM_BITS-1:0] w_col_ext, w_row_ext, w_col_inc, w_row_inc;
    logic                         w_acc, w_cfg_hit, w_last_col, w_last_row;
    logic [rwc_pkg::DIM_BITS-1:0] n_w, n_h;
    logic [2:0]                   n_k;

    logic                              r_v1, r_f1;
    logic [rwc_pkg::IDX_BITS-1:0]      r_ci1;
    logic [rwc_pkg::COEF_BITS-1:0]     r_cv1;
    logic [rwc_pkg::PIX_BITS-1:0]      r_px1;
    logic [rwc_pkg::X_BITS-1:0]        r_x1;
    rwc_pkg::t_meta                    r_m1, n_m1, r_m2;

    logic [rwc_pkg::LINE_WORD-1:0]     w_rdata, w_wdata;
    logic                              w_ram_we, w_ram_re;
    rwc_pkg::t_win                     r_win, w_win;
    rwc_pkg::t_coefs                   r_coef, w_coefs;

    assign w_acc      = i_valid && i_adv;
    assign w_cfg_hit  = i_cfg_we && (i_cfg_addr == rwc_pkg::CFG_WIDTH ||
                        i_cfg_addr == rwc_pkg::CFG_HEIGHT || i_cfg_addr == rwc_pkg::CFG_KERNEL);
    assign w_col_ext  = {1'b0, r_col};
    assign w_row_ext  = {1'b0, r_row};
    assign w_col_inc  = w_col_ext + 13'd1;
    assign w_row_inc  = w_row_ext + 13'd1;
    assign w_last_col = (w_col_inc == r_w);
    assign w_last_row = (w_row_inc == r_h);

    // clamp register writes to the used ranges
    always_comb begin
        n_w = i_cfg_data;
        if (n_w < 13'd3) begin
            n_w = 13'd3;
        end else if (n_w > 13'(rwc_pkg::MAX_WIDTH)) begin
            n_w = 13'(rwc_pkg::MAX_WIDTH);
        end
        n_h = i_cfg_data;
        if (n_h < 13'd3) begin
            n_h = 13'd3;
        end else if (n_h > 13'(rwc_pkg::MAX_HEIGHT)) begin
            n_h = 13'(rwc_pkg::MAX_HEIGHT);
        end
        case (i_cfg_data[2:0])
            3'd5, 3'd6: n_k = 3'd5;
            3'd7:       n_k = 3'd7;
            default:    n_k = 3'd3;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= 13'(rwc_pkg::MAX_WIDTH);
            r_h <= 13'(rwc_pkg::MAX_HEIGHT);
            r_k <= 3'd7;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                rwc_pkg::CFG_WIDTH:  r_w <= n_w;
                rwc_pkg::CFG_HEIGHT: r_h <= n_h;
                rwc_pkg::CFG_KERNEL: r_k <= n_k;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_cfg_hit) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_acc && i_func == rwc_pkg::FUNC_PIXEL) begin
            if (w_last_col) begin
                r_col <= '0;
                r_row <= w_last_row ? '0 : w_row_inc[rwc_pkg::X_BITS-1:0];
            end else begin
                r_col <= w_col_inc[rwc_pkg::X_BITS-1:0];
            end
        end
    end

    // result tag worked out at accept time
    always_comb begin
        n_m1.valid     = (w_col_inc >= {10'd0, r_k}) && (w_row_inc >= {10'd0, r_k});
        n_m1.x         = r_col - {9'd0, 1'b0, r_k[2:1]};
        n_m1.y         = r_row - {9'd0, 1'b0, r_k[2:1]};
        n_m1.frame_end = w_last_col && w_last_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_adv) begin
            r_v1 <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_f1  <= i_func;
            r_ci1 <= i_coef_index;
            r_cv1 <= i_coef_value;
            r_px1 <= i_px;
            r_x1  <= r_col;
            r_m1  <= n_m1;
        end
    end

    // read the column at accept, write the shifted column back when the pipeline next advances
    assign w_ram_re = w_acc && i_func == rwc_pkg::FUNC_PIXEL;
    assign w_ram_we = i_adv && r_v1 && r_f1 == rwc_pkg::FUNC_PIXEL;
    assign w_wdata  = {r_px1, w_rdata[rwc_pkg::LINE_WORD-1:rwc_pkg::PIX_BITS]};

    rwc_ram #(
        .WIDTH (rwc_pkg::LINE_WORD),
        .DEPTH (rwc_pkg::MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_x1),
        .i_wdata (w_wdata),
        .i_re    (w_ram_re),
        .i_raddr (r_col),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (w_ram_we) begin
            for (int r = 0; r < rwc_pkg::MAX_K; r++) begin
                for (int c = 0; c < rwc_pkg::MAX_K - 1; c++) begin
                    r_win[r*rwc_pkg::MAX_K + c] <= r_win[r*rwc_pkg::MAX_K + c + 1];
                end
                if (r == rwc_pkg::MAX_K - 1) begin
                    r_win[r*rwc_pkg::MAX_K + rwc_pkg::MAX_K - 1] <= r_px1;
                end else begin
                    r_win[r*rwc_pkg::MAX_K + rwc_pkg::MAX_K - 1] <=
                        w_rdata[r*rwc_pkg::PIX_BITS +: rwc_pkg::PIX_BITS];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
        end else if (i_adv && r_v1 && r_f1 == rwc_pkg::FUNC_COEF &&
                     r_ci1 < 6'(rwc_pkg::TAPS)) begin
            r_coef[r_ci1] <= r_cv1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m2.valid <= 1'b0;
        end else if (i_adv) begin
            r_m2.valid <= w_ram_we && r_m1.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_m2.x         <= r_m1.x;
            r_m2.y         <= r_m1.y;
            r_m2.frame_end <= r_m1.frame_end;
        end
    end

    // place each stored coefficient on its window tap for the current side;
    // taps outside the mask pass zero so stale line data never reaches the products
    for (genvar t = 0; t < rwc_pkg::TAPS; t++) begin : g_tap
        localparam logic [rwc_pkg::IDX_BITS:0] S3 =
            rwc_pkg::coef_slot(t / rwc_pkg::MAX_K, t % rwc_pkg::MAX_K, 3);
        localparam logic [rwc_pkg::IDX_BITS:0] S5 =
            rwc_pkg::coef_slot(t / rwc_pkg::MAX_K, t % rwc_pkg::MAX_K, 5);
        localparam logic [rwc_pkg::IDX_BITS:0] S7 =
            rwc_pkg::coef_slot(t / rwc_pkg::MAX_K, t % rwc_pkg::MAX_K, 7);
        always_comb begin
            case (r_k)
                3'd3: begin
                    w_coefs[t] = S3[rwc_pkg::IDX_BITS] ?
                                 r_coef[S3[rwc_pkg::IDX_BITS-1:0]] : '0;
                    w_win[t]   = S3[rwc_pkg::IDX_BITS] ? r_win[t] : '0;
                end
                3'd5: begin
                    w_coefs[t] = S5[rwc_pkg::IDX_BITS] ?
                                 r_coef[S5[rwc_pkg::IDX_BITS-1:0]] : '0;
                    w_win[t]   = S5[rwc_pkg::IDX_BITS] ? r_win[t] : '0;
                end
                default: begin
                    w_coefs[t] = S7[rwc_pkg::IDX_BITS] ?
                                 r_coef[S7[rwc_pkg::IDX_BITS-1:0]] : '0;
                    w_win[t]   = S7[rwc_pkg::IDX_BITS] ? r_win[t] : '0;
                end
            endcase
        end
    end

    assign o_win   = w_win;
    assign o_coefs = w_coefs;
    assign o_meta  = r_m2;

    `RWC_ASSERT_NOW(a_col_in_row, 1'b1, w_col_ext < r_w)
    `RWC_ASSERT_NOW(a_kernel_odd, 1'b1, r_k == 3'd3 || r_k == 3'd5 || r_k == 3'd7)
    `RWC_ASSERT_NEXT(a_row_wrap, w_ram_re && w_last_col && !i_cfg_we, r_col == '0)
    `RWC_ASSERT_NOW(a_no_rw_clash, w_ram_we && w_ram_re, r_x1 != r_col)
endmodule

/* rtl/rwc_mac.sv */
// multiply-accumulate pipeline, rounding, saturation and output register
module rwc_mac (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_m_tready,
    input  rwc_pkg::t_win    i_win,
    input  rwc_pkg::t_coefs  i_coefs,
    input  rwc_pkg::t_meta   i_meta,
    output logic             o_adv,
    output logic             o_m_tvalid,
    output logic [55:0]      o_m_tdata,
    output logic             o_m_tlast
);
    logic [3:0][rwc_pkg::TAPS-1:0][rwc_pkg::PROD_BITS-1:0]  r_prod;
    logic [3:0][rwc_pkg::MAX_K-1:0][rwc_pkg::ROW_BITS-1:0]  r_rows, n_rows;
    logic [3:0][rwc_pkg::SUM_BITS-1:0]                      n_sum;
    logic [3:0][7:0]                                        n_res;
    rwc_pkg::t_meta                                         r_m3, r_m4;
    logic                                                   r_vout;
    logic [55:0]                                            r_data;
    logic                                                   r_last;
    logic                                                   w_adv;

    assign w_adv = !r_vout || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            for (int ch = 0; ch < 4; ch++) begin
                for (int t = 0; t < rwc_pkg::TAPS; t++) begin
                    r_prod[ch][t] <= rwc_pkg::PROD_BITS'(i_coefs[t]) *
                                     rwc_pkg::PROD_BITS'(i_win[t][8*ch +: 8]);
                end
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < 4; ch++) begin
            for (int r = 0; r < rwc_pkg::MAX_K; r++) begin
                n_rows[ch][r] = '0;
                for (int c = 0; c < rwc_pkg::MAX_K; c++) begin
                    n_rows[ch][r] = n_rows[ch][r] +
                        rwc_pkg::ROW_BITS'(r_prod[ch][r*rwc_pkg::MAX_K + c]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rows <= n_rows;
        end
    end

    // sum the rows, add one half and keep the integer part, saturating to 255
    always_comb begin
        for (int ch = 0; ch < 4; ch++) begin
            n_sum[ch] = rwc_pkg::SUM_BITS'(1) << (rwc_pkg::COEF_BITS - 1);
            for (int r = 0; r < rwc_pkg::MAX_K; r++) begin
                n_sum[ch] = n_sum[ch] + rwc_pkg::SUM_BITS'(r_rows[ch][r]);
            end
            if (n_sum[ch][rwc_pkg::SUM_BITS-1:rwc_pkg::COEF_BITS+8] != '0) begin
                n_res[ch] = 8'hFF;
            end else begin
                n_res[ch] = n_sum[ch][rwc_pkg::COEF_BITS +: 8];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m3.valid <= 1'b0;
            r_m4.valid <= 1'b0;
            r_vout     <= 1'b0;
        end else if (w_adv) begin
            r_m3.valid <= i_meta.valid;
            r_m4.valid <= r_m3.valid;
            r_vout     <= r_m4.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_m3.x         <= i_meta.x;
            r_m3.y         <= i_meta.y;
            r_m3.frame_end <= i_meta.frame_end;
            r_m4.x         <= r_m3.x;
            r_m4.y         <= r_m3.y;
            r_m4.frame_end <= r_m3.frame_end;
            r_data         <= {n_res[3], n_res[2], n_res[1], n_res[0], r_m4.y, r_m4.x};
            r_last         <= r_m4.frame_end;
        end
    end

    assign o_adv      = w_adv;
    assign o_m_tvalid = r_vout;
    assign o_m_tdata  = r_data;
    assign o_m_tlast  = r_last;
endmodule

/* rtl/rgba_window_convolution_unit.sv */
// top level of the rgba window convolution unit
//
// Filters an RGBA raster stream with a square mask of side 3, 5 or 7.
// Input requests arrive on the s channel: tuser low writes one coefficient
// (tdata holds slot and Q0.16 value), tuser high delivers one pixel.
// Results leave on the m channel, one per interior centre pixel, with the
// centre column and row; tlast marks the last result of the image.
// Image width, height and mask side are set over the config write port;
// the user must set them only while the unit is drained, which the unit
// does not enforce. Each write to one of them restarts the frame at column 0
// row 0. One request is taken every clock while s_tready is high. A result
// passes from its pixel through the line memory read at the accept edge,
// window shift, products, row sums and output register. The rate is set by
// the line memory, which reads one column per pixel and writes it back shifted.
// When the receiver stalls with a result held, the whole pipeline freezes
// and s_tready drops in the same cycle.
// Reset clears counters, window and coefficients and restores the
// full-size defaults; line memory contents stay undefined until written.
module rgba_window_convolution_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,  // coef_index, coef_value, chan0, chan1, chan2, chan3
    input  logic        i_s_tuser,  // func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,  // out_x, out_y, res0, res1, res2, res3
    output logic        o_m_tlast,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [12:0] i_cfg_data
);
    logic             w_adv;
    rwc_pkg::t_win    w_win;
    rwc_pkg::t_coefs  w_coefs;
    rwc_pkg::t_meta   w_meta;

    rwc_line_window u_line_window (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_valid      (i_s_tvalid),
        .i_func       (i_s_tuser),
        .i_coef_index (i_s_tdata[5:0]),
        .i_coef_value (i_s_tdata[21:6]),
        .i_px         (i_s_tdata[53:22]),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_data   (i_cfg_data),
        .o_win        (w_win),
        .o_coefs      (w_coefs),
        .o_meta       (w_meta)
    );

    rwc_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_m_tready (i_m_tready),
        .i_win      (w_win),
        .i_coefs    (w_coefs),
        .i_meta     (w_meta),
        .o_adv      (w_adv),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    assign o_s_tready = w_adv;
endmodule
